[rtl/core/bffz_pkg.sv]
`default_nettype none

package bffz_pkg;

    localparam int MODE_W           = 2;
    localparam int INDEX_W          = 12;
    localparam int BYTE_IDX_W       = 9;
    localparam int POS_W            = 3;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 10;
    localparam int IN_DATA_W        = 16;
    localparam int OUT_DATA_W       = 16;
    localparam int INDEX_SPAN_BYTES = 512;
    localparam int DEF_MAP_BYTES    = 512;

    localparam logic [LEN_W-1:0] MAP_BYTES_RST = LEN_W'(512);

    typedef enum logic [MODE_W-1:0] {
        MODE_TEST  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_FIND  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic access;
        logic scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic in_find;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/bffz_ctrl.sv]
`default_nettype none

module bffz_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output bffz_pkg::t_cmd   o_cmd,
    input  bffz_pkg::t_sts   i_sts
);
    import bffz_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.in_find ? ST_SCAN : ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state      = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/bffz_dp.sv]
`default_nettype none

module bffz_dp #(
    parameter int MAP_BYTES = bffz_pkg::DEF_MAP_BYTES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [bffz_pkg::LEN_W-1:0]          i_cfg_wdata,
    input  wire  [bffz_pkg::MODE_W-1:0]         i_in_mode,
    input  wire  [bffz_pkg::INDEX_W-1:0]        i_in_index,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_out_bit,
    output logic                                o_out_found,
    output logic [bffz_pkg::INDEX_W-1:0]        o_out_zero,
    input  bffz_pkg::t_cmd                      i_cmd,
    output bffz_pkg::t_sts                      o_sts
);
    import bffz_pkg::*;

    localparam int AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int SPAN = (MAP_BYTES < INDEX_SPAN_BYTES) ? MAP_BYTES : INDEX_SPAN_BYTES;

    function automatic logic [POS_W-1:0] low_zero(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] j;
        j = '0;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (!b[k]) begin
                j = POS_W'(k);
            end
        end
        return j;
    endfunction

    logic [BYTE_W-1:0]     r_mem [MAP_BYTES];
    logic [BYTE_W-1:0]     r_rd_data;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [BYTE_W-1:0]     mem_wd;

    logic [LEN_W-1:0]      r_map_bytes;
    logic [AW-1:0]         r_clr_addr;

    t_mode                 r_mode;
    logic [BYTE_IDX_W-1:0] r_byte;
    logic [POS_W-1:0]      r_pos;
    logic                  r_in_range;

    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_issue;
    logic                  r_pend;
    logic [BYTE_IDX_W-1:0] r_pend_idx;

    logic                  r_res_bit;
    logic                  r_res_found;
    logic [INDEX_W-1:0]    r_res_zero;

    logic                  r_out_valid;
    logic                  r_out_bit;
    logic                  r_out_found;
    logic [INDEX_W-1:0]    r_out_zero;

    logic [BYTE_IDX_W-1:0] in_byte;
    logic                  in_range;
    logic [LEN_W-1:0]      len_sat;
    logic                  issue_ok;
    logic [BYTE_W-1:0]     mask;
    logic                  hit;

    assign in_byte  = i_in_index[INDEX_W-1:POS_W];
    assign in_range = 32'(in_byte) < 32'(MAP_BYTES);
    assign len_sat  = (r_map_bytes > LEN_W'(SPAN)) ? LEN_W'(SPAN) : r_map_bytes;
    assign issue_ok = r_issue < r_len;
    assign mask     = BYTE_W'(1) << r_pos;
    assign hit      = r_pend && (r_rd_data != '1);

    always_comb begin
        rd_addr = i_cmd.scan ? AW'(r_issue) : AW'(in_byte);
        mem_we  = 1'b0;
        mem_wa  = AW'(r_byte);
        mem_wd  = r_rd_data | mask;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else if (i_cmd.access && r_in_range) begin
            mem_we = (r_mode == MODE_SET) || (r_mode == MODE_CLEAR);
            mem_wd = (r_mode == MODE_SET) ? (r_rd_data | mask) : (r_rd_data & ~mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bytes <= MAP_BYTES_RST;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_map_bytes <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.accept) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue_ok;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode      <= t_mode'(i_in_mode);
            r_byte      <= in_byte;
            r_pos       <= i_in_index[POS_W-1:0];
            r_in_range  <= in_range;
            r_len       <= len_sat;
            r_issue     <= '0;
            r_res_bit   <= 1'b0;
            r_res_found <= 1'b0;
            r_res_zero  <= '0;
        end
        if (i_cmd.access) begin
            r_res_bit <= r_in_range && r_rd_data[r_pos];
        end
        if (i_cmd.scan) begin
            r_pend_idx <= r_issue[BYTE_IDX_W-1:0];
            if (issue_ok) begin
                r_issue <= r_issue + LEN_W'(1);
            end
            if (hit) begin
                r_res_found <= 1'b1;
                r_res_zero  <= {r_pend_idx, low_zero(r_rd_data)};
            end
        end
        if (i_cmd.load_out) begin
            r_out_bit   <= r_res_bit;
            r_out_found <= r_res_found;
            r_out_zero  <= r_res_zero;
        end
    end

    assign o_sts.clear_last = r_clr_addr == AW'(MAP_BYTES - 1);
    assign o_sts.in_find    = t_mode'(i_in_mode) == MODE_FIND;
    assign o_sts.scan_hit   = hit;
    assign o_sts.scan_end   = !r_pend && !issue_ok;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_bit   = r_out_bit;
    assign o_out_found = r_out_found;
    assign o_out_zero  = r_out_zero;

endmodule

`default_nettype wire

[rtl/core/bitmap_find_first_zero.sv]
// Channel  Dir  Handshake                          Payload (low bit up)
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready  tdata: bit_index; tuser: mode
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready  tdata: bit_value, zero_index; tuser: found
// cfg      in   i_cfg_we                           i_cfg_wdata: map_bytes
//
// Test, set and clear: after accept the item passes read, modify/write and load of the result
// register. Find: the scan reads one byte after another and stops at the first zero bit or at
// the end of the span of n bytes; n is at most min(map_bytes, MAP_BYTES, 512).
// One bitmap byte per cycle through the RAM read port.
// After reset a clearing pass writes zeros to all MAP_BYTES bytes; o_s_axis_tready stays low.
// One item in flight; the next is taken while the previous result waits on i_m_axis_tready.
`default_nettype none

module bitmap_find_first_zero #(
    parameter int MAP_BYTES = bffz_pkg::DEF_MAP_BYTES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [bffz_pkg::LEN_W-1:0]          i_cfg_wdata,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire  [bffz_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,   // [11:0] bit_index
    input  wire  [bffz_pkg::MODE_W-1:0]         i_s_axis_tuser,   // [1:0] mode
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [bffz_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,   // [0] bit_value, [12:1] zero_index
    output logic                                o_m_axis_tuser    // [0] found
);
    import bffz_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic               out_bit;
    logic               out_found;
    logic [INDEX_W-1:0] out_zero;

    bffz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bffz_dp #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_mode   (i_s_axis_tuser),
        .i_in_index  (i_s_axis_tdata[INDEX_W-1:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_bit   (out_bit),
        .o_out_found (out_found),
        .o_out_zero  (out_zero),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - INDEX_W - 1)'(0), out_zero, out_bit};
    assign o_m_axis_tuser = out_found;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.accept, cmd.access, cmd.scan, cmd.load_out}))
        else $error("controller issued overlapping commands");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item accepted while one is in work");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !o_s_axis_tready)
        else $error("item accepted during clearing pass");

endmodule

`default_nettype wire

[tb/bitmap_alloc_checker.sv]
`timescale 1ns / 1ps

module bitmap_alloc_checker #(
    parameter int MAP_BYTES = bffz_pkg::DEF_MAP_BYTES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [bffz_pkg::LEN_W-1:0]          i_cfg_wdata,
    input  wire                                 i_s_axis_tvalid,
    input  wire                                 o_s_axis_tready,
    input  wire  [bffz_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,   // [11:0] bit_index
    input  wire  [bffz_pkg::MODE_W-1:0]         i_s_axis_tuser,   // [1:0] mode
    input  wire                                 o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    input  wire  [bffz_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,   // [0] bit_value, [12:1] zero_index
    input  wire                                 o_m_axis_tuser,   // [0] found
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import bffz_pkg::*;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] zero_index;
    } alloc_result_t;

    logic [BYTE_W-1:0] bitmap_mem [MAP_BYTES];
    logic [LEN_W-1:0]  search_span;
    alloc_result_t     alloc_results_q [$];
    int                result_count;

    // Applies one operation to the shadow bitmap and returns the result it must produce.
    function automatic alloc_result_t apply_bitmap_op(t_mode op, logic [INDEX_W-1:0] idx);
        alloc_result_t r;
        int unsigned   span;
        int unsigned   b;
        int unsigned   p;
        r = '0;
        if (op == MODE_FIND) begin
            span = 32'(search_span);
            if (span > MAP_BYTES) span = MAP_BYTES;
            if (span > INDEX_SPAN_BYTES) span = INDEX_SPAN_BYTES;
            for (b = 0; b < span && !r.found; b++) begin
                if (bitmap_mem[b] != 8'hFF) begin
                    for (p = 0; p < BYTE_W; p++) begin
                        if (!bitmap_mem[b][p] && !r.found) begin
                            r.found      = 1'b1;
                            r.zero_index = INDEX_W'(b * BYTE_W + p);
                        end
                    end
                end
            end
        end else begin
            b = 32'(idx >> POS_W);
            p = 32'(idx[POS_W-1:0]);
            if (b < MAP_BYTES) begin
                r.bit_value = bitmap_mem[b][p];
                if (op == MODE_SET) begin
                    bitmap_mem[b][p] = 1'b1;
                end else if (op == MODE_CLEAR) begin
                    bitmap_mem[b][p] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        alloc_result_t want;
        if (!i_rst_n) begin
            foreach (bitmap_mem[k]) bitmap_mem[k] = '0;
            search_span  = MAP_BYTES_RST;
            alloc_results_q.delete();
            result_count = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                search_span = i_cfg_wdata;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                alloc_results_q.push_back(apply_bitmap_op(t_mode'(i_s_axis_tuser),
                                                          i_s_axis_tdata[INDEX_W-1:0]));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (alloc_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                              result_count));
                end else begin
                    want = alloc_results_q.pop_front();
                    if (o_m_axis_tdata[0] !== want.bit_value) begin
                        report_mismatch($sformatf("result %0d bit_value got %b want %b",
                                                  result_count, o_m_axis_tdata[0],
                                                  want.bit_value));
                    end
                    if (o_m_axis_tuser !== want.found) begin
                        report_mismatch($sformatf("result %0d found got %b want %b",
                                                  result_count, o_m_axis_tuser, want.found));
                    end
                    if (o_m_axis_tdata[INDEX_W:1] !== want.zero_index) begin
                        report_mismatch($sformatf("result %0d zero_index got %0d want %0d",
                                                  result_count, o_m_axis_tdata[INDEX_W:1],
                                                  want.zero_index));
                    end
                end
                result_count++;
            end
        end
        o_pending = alloc_results_q.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bffz_pkg::*;

    localparam int MAP_BYTES   = DEF_MAP_BYTES;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 180;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // [11:0] bit_index
    logic [MODE_W-1:0]     i_s_axis_tuser = '0;   // [1:0] mode
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // [0] bit_value, [12:1] zero_index
    logic                  o_m_axis_tuser;        // [0] found

    int fail_count;
    int pending_results;
    int src_idle_pct = 12;
    int snk_idle_pct = 50;
    int cycle_count = 0;
    int seg_items = 0;
    int alloc_next = 0;

    bitmap_find_first_zero #(
        .MAP_BYTES(MAP_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    bitmap_alloc_checker #(
        .MAP_BYTES(MAP_BYTES)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input t_mode op, input logic [INDEX_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= IN_DATA_W'(idx);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        seg_items++;
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic load_search_span(input logic [LEN_W-1:0] span);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= span;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [LEN_W-1:0] span;
        int               pick;
        int               burst;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner bits, byte skip, search span limits
        send_item(MODE_TEST, 12'd0);
        send_item(MODE_FIND, 12'd0);
        send_item(MODE_SET, 12'd0);
        send_item(MODE_TEST, 12'd0);
        send_item(MODE_SET, 12'd0);
        send_item(MODE_SET, 12'hFFF);
        send_item(MODE_TEST, 12'hFFF);
        send_item(MODE_FIND, 12'hFFF);
        for (int b = 1; b < BYTE_W; b++) begin
            send_item(MODE_SET, INDEX_W'(b));
        end
        send_item(MODE_FIND, 12'd0);
        send_item(MODE_CLEAR, 12'hFFF);
        send_item(MODE_TEST, 12'hFFF);
        send_item(MODE_CLEAR, 12'hFFF);
        send_item(MODE_SET, 12'hAAA);
        send_item(MODE_TEST, 12'h555);
        load_search_span(10'd1);
        send_item(MODE_FIND, 12'd0);
        load_search_span(10'd0);
        send_item(MODE_FIND, 12'd0);
        load_search_span(10'h3FF);
        send_item(MODE_CLEAR, 12'd3);
        send_item(MODE_FIND, 12'd0);
        send_item(MODE_TEST, 12'hAAA);

        // random: mostly allocation-style fill from the bottom, with holes and noise
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       span = 10'h3FF;
                1:       span = LEN_W'($urandom_range(1, 64));
                2:       span = MAP_BYTES_RST;
                3:       span = LEN_W'($urandom_range(0, 1023));
                4:       span = 10'd1;
                default: span = LEN_W'($urandom_range(1, 48));
            endcase
            load_search_span(span);
            if (seg < 2) begin
                src_idle_pct = 12;
                snk_idle_pct = 50;
            end else if (seg < 4) begin
                src_idle_pct = 50;
                snk_idle_pct = 12;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            seg_items = 0;
            while (seg_items < SEG_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    send_item(MODE_FIND, INDEX_W'($urandom));
                end else if (pick < 42) begin
                    burst = $urandom_range(1, 12);
                    repeat (burst) begin
                        send_item(MODE_SET, alloc_next[INDEX_W-1:0]);
                        alloc_next = (alloc_next + 1) % 4096;
                    end
                end else if (pick < 57) begin
                    send_item(MODE_SET, INDEX_W'($urandom_range(0, alloc_next)));
                end else if (pick < 65) begin
                    send_item(MODE_CLEAR, INDEX_W'($urandom_range(0, alloc_next)));
                end else if (pick < 77) begin
                    send_item(MODE_TEST, INDEX_W'($urandom_range(0, alloc_next + 8)));
                end else begin
                    send_item(t_mode'($urandom_range(0, 3)), INDEX_W'($urandom_range(0, 4095)));
                end
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
